// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the bridge forwarder RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

// ----- hw/rtl/mlbf_pkg.sv -----
// Package for the MAC learning bridge forwarder: payload types, action codes, constants.
// No dependencies.
package mlbf_pkg;
   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int MAX_PORTS_DEF = 16;
   localparam int RESULT_LIMIT = 14;
   localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] ACT_FORWARD = 3'd0;
   localparam logic [2:0] ACT_BAD_LENGTH = 3'd1;
   localparam logic [2:0] ACT_WRONG_SIDE = 3'd2;
   localparam logic [2:0] ACT_MOVED = 3'd3;
   localparam logic [2:0] ACT_NO_DEST = 3'd4;
   localparam logic [2:0] ACT_DEST_UPLINK = 3'd5;

   localparam logic CSR_UPLINK_PORT = 1'b0;
   localparam logic CSR_PORT_COUNT = 1'b1;

   typedef struct packed {
      logic [3:0] ingress_port;
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic length_ok;
   } req_type;

   typedef struct packed {
      logic [3:0] egress_port;
      logic [2:0] action;
      logic learned;
      logic table_full;
      logic last_result;
   } rsp_type;

   // Decided frame: either a single result or a flood.
   typedef struct packed {
      logic flood;
      logic [3:0] egress_port;
      logic [2:0] action;
      logic learned;
      logic table_full;
   } dec_type;
endpackage

// ----- hw/rtl/mlbf_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module mlbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- hw/rtl/mlbf_front.sv -----
// Front part: takes a header, searches the table entry by entry, learns or moves
// the source, and pushes a decision. Uses mlbf_pkg and mlbf_ram.
module mlbf_front #(
   parameter int TABLE_ENTRIES = mlbf_pkg::TABLE_ENTRIES_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input mlbf_pkg::req_type req_data,
   input logic [3:0] uplink_port,
   output logic dec_valid,
   output mlbf_pkg::dec_type dec_data,
   input logic dec_space
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int CW = AW + 1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SRC  = 5'b00010,
      S_DST  = 5'b00100,
      S_WAIT = 5'b01000,
      S_PUSH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   mlbf_pkg::req_type req_ff, req_in;
   logic [CW-1:0] used_ff, used_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic rd_pend_ff, rd_pend_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic src_hit_ff, src_hit_in;
   logic [AW-1:0] src_idx_ff, src_idx_in;
   logic [3:0] src_port_ff, src_port_in;
   mlbf_pkg::dec_type dec_ff, dec_in;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [51:0] wr_data, rd_data;
   logic [AW-1:0] rd_addr;
   logic is_up, bcast, match, full, last_rd;
   logic [47:0] key;

   mlbf_ram #(.WIDTH(52), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign busy = (state_ff != S_IDLE);
   assign dec_valid = (state_ff == S_PUSH);
   assign dec_data = dec_ff;
   assign is_up = (req_ff.ingress_port == uplink_port);
   assign bcast = (req_ff.dest_mac == mlbf_pkg::BROADCAST_MAC);
   assign full = (used_ff == CW'(TABLE_ENTRIES));
   assign key = (state_ff == S_DST) ? req_ff.dest_mac : req_ff.source_mac;
   assign match = rd_pend_ff && (rd_data[51:4] == key);
   assign last_rd = ({1'b0, rd_idx_ff} == used_ff - CW'(1));
   assign rd_addr = idx_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      used_in = used_ff;
      idx_in = idx_ff;
      rd_pend_in = 1'b0;
      rd_idx_in = idx_ff;
      src_hit_in = src_hit_ff;
      src_idx_in = src_idx_ff;
      src_port_in = src_port_ff;
      dec_in = dec_ff;
      wr_en = 1'b0;
      wr_addr = used_ff[AW-1:0];
      wr_data = {req_ff.source_mac, req_ff.ingress_port};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               idx_in = '0;
               src_hit_in = 1'b0;
               dec_in = '0;
               state_in = S_SRC;
            end
         end
         S_SRC, S_DST: begin
            if (!req_ff.length_ok) begin
               dec_in.action = mlbf_pkg::ACT_BAD_LENGTH;
               state_in = S_PUSH;
            end else if (match || (rd_pend_ff && last_rd) || used_ff == '0) begin
               if (state_ff == S_SRC) begin
                  src_hit_in = match;
                  src_idx_in = rd_idx_ff;
                  src_port_in = rd_data[3:0];
                  state_in = S_WAIT;
               end else begin
                  // destination lookup result, source known on uplink
                  if (!match) begin
                     if (bcast) dec_in.flood = 1'b1;
                     else dec_in.action = mlbf_pkg::ACT_NO_DEST;
                  end else if (rd_data[3:0] != uplink_port) begin
                     dec_in.egress_port = rd_data[3:0];
                  end else begin
                     dec_in.action = mlbf_pkg::ACT_DEST_UPLINK;
                  end
                  state_in = S_PUSH;
               end
            end else begin
               // issue next read while scanning the filled part
               if (!rd_pend_ff || {1'b0, idx_ff} < used_ff) begin
                  rd_pend_in = ({1'b0, idx_ff} < used_ff);
                  rd_idx_in = idx_ff;
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         S_WAIT: begin
            state_in = S_PUSH;
            if (src_hit_ff) begin
               if (is_up) begin
                  if (src_port_ff != uplink_port) begin
                     dec_in.action = mlbf_pkg::ACT_WRONG_SIDE;
                  end else begin
                     idx_in = '0;
                     state_in = S_DST;
                  end
               end else if (src_port_ff == uplink_port) begin
                  dec_in.action = mlbf_pkg::ACT_WRONG_SIDE;
               end else if (src_port_ff != req_ff.ingress_port) begin
                  wr_en = 1'b1;
                  wr_addr = src_idx_ff;
                  dec_in.action = mlbf_pkg::ACT_MOVED;
               end else begin
                  dec_in.egress_port = uplink_port;
               end
            end else begin
               if (full) begin
                  dec_in.table_full = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  used_in = used_ff + CW'(1);
                  dec_in.learned = 1'b1;
               end
               if (is_up) begin
                  if (bcast) dec_in.flood = 1'b1;
                  else dec_in.action = mlbf_pkg::ACT_NO_DEST;
               end else if (bcast) begin
                  dec_in.egress_port = uplink_port;
               end else begin
                  dec_in.action = mlbf_pkg::ACT_NO_DEST;
               end
            end
         end
         S_PUSH: begin
            if (dec_space) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         rd_pend_ff <= rd_pend_in;
      end
      req_ff <= req_in;
      idx_ff <= idx_in;
      rd_idx_ff <= rd_idx_in;
      src_hit_ff <= src_hit_in;
      src_idx_ff <= src_idx_in;
      src_port_ff <= src_port_in;
      dec_ff <= dec_in;
   end
endmodule

// ----- hw/rtl/mlbf_back.sv -----
// Back part: pops decisions from a small queue and emits each decision's results, one per cycle.
// Uses mlbf_pkg.
module mlbf_back #(
   parameter int MAX_PORTS = mlbf_pkg::MAX_PORTS_DEF
) (
   input logic clock,
   input logic reset,
   input logic dec_valid,
   input mlbf_pkg::dec_type dec_data,
   output logic dec_space,
   input logic [3:0] uplink_port,
   input logic [4:0] port_count,
   output logic idle,
   output logic rsp_strobe,
   output mlbf_pkg::rsp_type rsp_data
);
   localparam logic [4:0] PortCap = (MAX_PORTS < 16) ? 5'(MAX_PORTS) : 5'd16;

   mlbf_pkg::dec_type q_ff [2];
   logic [1:0] q_cnt_ff, q_cnt_in;
   logic rd_ptr_ff, wr_ptr_ff;
   logic act_ff, act_in;
   mlbf_pkg::dec_type cur_ff, cur_in;
   logic [4:0] port_ff, port_in;
   logic [3:0] sent_ff, sent_in;
   logic strobe_ff, strobe_in;
   mlbf_pkg::rsp_type rsp_ff, rsp_in;
   logic push, pop;
   logic [4:0] bound, p, nxt;
   logic done;

   assign dec_space = (q_cnt_ff != 2'd2);
   assign push = dec_valid && dec_space;
   assign idle = (q_cnt_ff == '0) && !act_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;
   assign bound = (port_count > PortCap) ? PortCap : port_count;

   always_comb begin
      pop = 1'b0;
      act_in = act_ff;
      cur_in = cur_ff;
      port_in = port_ff;
      sent_in = sent_ff;
      strobe_in = 1'b0;
      rsp_in = rsp_ff;
      p = port_ff;
      nxt = port_ff;
      done = 1'b0;
      if (!act_ff) begin
         if (q_cnt_ff != '0) begin
            pop = 1'b1;
            act_in = 1'b1;
            cur_in = q_ff[rd_ptr_ff];
            port_in = 5'd1;
            sent_in = '0;
         end
      end else if (!cur_ff.flood) begin
         strobe_in = 1'b1;
         rsp_in = '{cur_ff.egress_port, cur_ff.action, cur_ff.learned,
                    cur_ff.table_full, 1'b1};
         act_in = 1'b0;
      end else begin
         // skip the uplink port, then emit one port
         p = (port_ff[3:0] == uplink_port && port_ff < 5'd16) ? port_ff + 5'd1 : port_ff;
         nxt = (p + 5'd1 == {1'b0, uplink_port}) ? p + 5'd2 : p + 5'd1;
         if (p >= bound) begin
            act_in = 1'b0;
            if (sent_ff == '0) begin
               strobe_in = 1'b1;
               rsp_in = '{4'd0, mlbf_pkg::ACT_NO_DEST, cur_ff.learned,
                          cur_ff.table_full, 1'b1};
            end
         end else begin
            done = (nxt >= bound) || (sent_ff == 4'(mlbf_pkg::RESULT_LIMIT - 1));
            strobe_in = 1'b1;
            rsp_in = '{p[3:0], mlbf_pkg::ACT_FORWARD, cur_ff.learned,
                       cur_ff.table_full, done};
            sent_in = sent_ff + 4'd1;
            port_in = nxt;
            if (done) act_in = 1'b0;
         end
      end
      q_cnt_in = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // A flood whose range ends right after the last sent port must close with
   // last_result set; the lookahead above uses the next port after skipping.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         act_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         act_ff <= act_in;
         strobe_ff <= strobe_in;
      end
      if (push) q_ff[wr_ptr_ff] <= dec_data;
      cur_ff <= cur_in;
      port_ff <= port_in;
      sent_ff <= sent_in;
      rsp_ff <= rsp_in;
   end
endmodule

// ----- hw/rtl/mac_learning_bridge_forwarder_unit.sv -----
// Top level of the MAC learning bridge forwarder.
// Depends on mlbf_pkg, mlbf_front, mlbf_back and assert_macros.svh.
//
// Usage: pulse start with a header on req_data while busy is low. The front
// scans the filled part of the learned-address table one entry per cycle
// (one RAM read port): a source scan, then a destination scan for a source
// known on the uplink; the back then emits results one per cycle (up to 14
// for a flood). The two-deep queue decouples the two parts, but only one
// request is in flight at a time. Results appear on rsp_data with
// rsp_strobe high for exactly one cycle each; the receiver cannot stall.
// busy stays high until the last result of an accepted request is on
// rsp_data, so configuration written while busy is low is safe. No
// clearing pass: a fill count tracks the table.
`include "assert_macros.svh"
module mac_learning_bridge_forwarder_unit #(
   parameter int TABLE_ENTRIES = mlbf_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_PORTS = mlbf_pkg::MAX_PORTS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input mlbf_pkg::req_type req_data,
   output logic rsp_strobe,
   output mlbf_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic csr_index,
   input logic [4:0] csr_wdata
);
   logic [3:0] uplink_ff;
   logic [4:0] count_ff;
   logic front_busy, back_idle, dec_valid, dec_space;
   mlbf_pkg::dec_type dec_data;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         uplink_ff <= 4'd2;
         count_ff <= 5'd0;
      end else if (csr_we) begin
         case (csr_index)
            mlbf_pkg::CSR_UPLINK_PORT: uplink_ff <= csr_wdata[3:0];
            mlbf_pkg::CSR_PORT_COUNT: count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mlbf_front #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_front (
      .clock(clock), .reset(reset), .start(start && !busy), .busy(front_busy),
      .req_data(req_data), .uplink_port(uplink_ff), .dec_valid(dec_valid),
      .dec_data(dec_data), .dec_space(dec_space)
   );

   mlbf_back #(.MAX_PORTS(MAX_PORTS)) u_back (
      .clock(clock), .reset(reset), .dec_valid(dec_valid), .dec_data(dec_data),
      .dec_space(dec_space), .uplink_port(uplink_ff), .port_count(count_ff),
      .idle(back_idle), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // one request in flight at a time keeps configuration writes safe
   assign busy = front_busy || !back_idle;

   `ASSERT_CLK(a_start_busy, clock, reset, start && !busy |=> busy, "busy must follow a request")
   `ASSERT_IMPL(a_rsp_only_busy, clock, reset, rsp_strobe, busy || $past(busy), "stray result")
   `ASSERT_IMPL(a_fwd_port, clock, reset, rsp_strobe && rsp_data.action != mlbf_pkg::ACT_FORWARD, rsp_data.last_result && rsp_data.egress_port == 4'd0, "drop must be a single result on port 0")
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for mac_learning_bridge_forwarder_unit.
// Depends on mlbf_pkg and the bridge forwarder RTL; predicts every result in-line.
`timescale 1ns / 100ps
module tb;
   localparam int N_ENTRIES = 64;
   localparam int N_RANDOM = 360;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   mlbf_pkg::req_type req_data = '0;
   logic rsp_strobe;
   mlbf_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [4:0] csr_wdata = '0;

   mac_learning_bridge_forwarder_unit DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow of the learned-address table and the two registers.
   logic        tbl_valid [N_ENTRIES];
   logic [47:0] tbl_mac [N_ENTRIES];
   logic [3:0]  tbl_port [N_ENTRIES];
   int          tbl_used;
   logic [3:0]  sh_uplink;
   logic [4:0]  sh_count;

   mlbf_pkg::req_type pending_reqs[$];
   mlbf_pkg::rsp_type expected_rsps[$];
   int mismatches = 0;
   int accepted = 0;
   int results_seen = 0;
   bit allow_gaps = 1;
   bit hold_driver = 0;
   int gap_left = 0;
   int idle_cycles = 0;

   function automatic int find_mac(logic [47:0] mac);
      for (int k = 0; k < N_ENTRIES; k++)
         if (tbl_valid[k] && tbl_mac[k] == mac) return k;
      return -1;
   endfunction

   // Enter a source address; returns 0 when the table is full.
   function automatic bit learn_mac(logic [47:0] mac, logic [3:0] port);
      if (tbl_used >= N_ENTRIES) return 0;
      tbl_valid[tbl_used] = 1'b1;
      tbl_mac[tbl_used] = mac;
      tbl_port[tbl_used] = port;
      tbl_used++;
      return 1;
   endfunction

   // Work out the results of one request and advance the shadow table.
   function automatic void predict_forwarding(mlbf_pkg::req_type r);
      logic [3:0] ports[$];
      logic [2:0] acts[$];
      logic lrn, full;
      int hit, d, bound;
      bit flood_it, bcast;
      mlbf_pkg::rsp_type e;
      lrn = 0; full = 0; flood_it = 0;
      bcast = (r.dest_mac == mlbf_pkg::BROADCAST_MAC);
      if (!r.length_ok) begin
         ports.push_back(0); acts.push_back(mlbf_pkg::ACT_BAD_LENGTH);
      end else if (r.ingress_port == sh_uplink) begin
         hit = find_mac(r.source_mac);
         if (hit >= 0) begin
            if (tbl_port[hit] != sh_uplink) begin
               ports.push_back(0); acts.push_back(mlbf_pkg::ACT_WRONG_SIDE);
            end else begin
               d = find_mac(r.dest_mac);
               if (d >= 0) begin
                  if (tbl_port[d] != sh_uplink) begin
                     ports.push_back(tbl_port[d]); acts.push_back(mlbf_pkg::ACT_FORWARD);
                  end else begin
                     ports.push_back(0); acts.push_back(mlbf_pkg::ACT_DEST_UPLINK);
                  end
               end else if (bcast) flood_it = 1;
               else begin
                  ports.push_back(0); acts.push_back(mlbf_pkg::ACT_NO_DEST);
               end
            end
         end else begin
            if (learn_mac(r.source_mac, sh_uplink)) lrn = 1; else full = 1;
            if (bcast) flood_it = 1;
            else begin
               ports.push_back(0); acts.push_back(mlbf_pkg::ACT_NO_DEST);
            end
         end
      end else begin
         hit = find_mac(r.source_mac);
         if (hit >= 0) begin
            if (tbl_port[hit] == sh_uplink) begin
               ports.push_back(0); acts.push_back(mlbf_pkg::ACT_WRONG_SIDE);
            end else if (tbl_port[hit] != r.ingress_port) begin
               tbl_port[hit] = r.ingress_port;
               ports.push_back(0); acts.push_back(mlbf_pkg::ACT_MOVED);
            end else begin
               ports.push_back(sh_uplink); acts.push_back(mlbf_pkg::ACT_FORWARD);
            end
         end else begin
            ports.push_back(bcast ? sh_uplink : 4'd0);
            acts.push_back(bcast ? mlbf_pkg::ACT_FORWARD : mlbf_pkg::ACT_NO_DEST);
            if (learn_mac(r.source_mac, r.ingress_port)) lrn = 1; else full = 1;
         end
      end
      if (flood_it) begin
         bound = (sh_count > 16) ? 16 : sh_count;
         for (int p = 1; p < bound && ports.size() < mlbf_pkg::RESULT_LIMIT; p++)
            if (p != sh_uplink) begin
               ports.push_back(p[3:0]); acts.push_back(mlbf_pkg::ACT_FORWARD);
            end
         if (ports.size() == 0) begin
            ports.push_back(0); acts.push_back(mlbf_pkg::ACT_NO_DEST);
         end
      end
      foreach (ports[i]) begin
         e.egress_port = ports[i];
         e.action = acts[i];
         e.learned = lrn;
         e.table_full = full;
         e.last_result = (i == ports.size() - 1);
         expected_rsps.push_back(e);
      end
   endfunction

   // Driver: present queued requests, with random idle bursts.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !busy) begin
         // current request taken: load the next one or drop start
         predict_forwarding(req_data);
         accepted++;
         if (pending_reqs.size() > 0 && !hold_driver &&
             !(allow_gaps && $urandom_range(0, 5) == 0)) begin
            req_data <= pending_reqs.pop_front();
         end else begin
            start <= 1'b0;
            gap_left <= allow_gaps ? $urandom_range(1, 9) : 0;
         end
      end else if (!start) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else if (pending_reqs.size() > 0 && !hold_driver) begin
            req_data <= pending_reqs.pop_front();
            start <= 1'b1;
         end
      end
   end

   // Monitor: compare each result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result %p", rsp_data);
         end else begin
            mlbf_pkg::rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data !== e) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", e, rsp_data);
            end
         end
      end
   end

   // Watchdog: count cycles where nothing moves.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("TEST FAILED");
         $finish;
      end
   end

   // Small address pool so sources repeat and move between ports.
   function automatic logic [47:0] pool_mac(int i);
      return {8'h02, 8'h00, 16'h0, 8'h00, i[7:0]} ^ {i[0], 47'h0};
   endfunction

   function automatic mlbf_pkg::req_type make_req(logic [3:0] ing, logic [47:0] dst,
                                                  logic [47:0] src, logic ok);
      mlbf_pkg::req_type r;
      r.ingress_port = ing; r.dest_mac = dst; r.source_mac = src; r.length_ok = ok;
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || start || busy || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [4:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == mlbf_pkg::CSR_UPLINK_PORT) sh_uplink = val[3:0];
      else sh_count = val;
   endtask

   function automatic logic [47:0] rand_mac();
      case ($urandom_range(0, 9))
         0: return mlbf_pkg::BROADCAST_MAC;
         1: return 48'({$urandom(), $urandom()});
         2: return 48'h0;
         default: return pool_mac($urandom_range(0, 79));
      endcase
   endfunction

   initial begin
      logic [3:0] ing;
      for (int k = 0; k < N_ENTRIES; k++) begin
         tbl_valid[k] = 0; tbl_mac[k] = '0; tbl_port[k] = '0;
      end
      tbl_used = 0; sh_uplink = 2; sh_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty flood at reset values: port count 0.
      pending_reqs.push_back(make_req(4'd2, mlbf_pkg::BROADCAST_MAC, pool_mac(1), 1));
      wait_drained();
      write_csr(mlbf_pkg::CSR_PORT_COUNT, 5'd16);
      write_csr(mlbf_pkg::CSR_UPLINK_PORT, 5'd2);
      // Directed: bad length, learning on both sides, wrong side, moved,
      // forwards, destination on uplink, full flood (14 ports), extremes.
      pending_reqs.push_back(make_req(4'd5, mlbf_pkg::BROADCAST_MAC, pool_mac(2), 0));
      pending_reqs.push_back(make_req(4'd2, mlbf_pkg::BROADCAST_MAC, pool_mac(1), 1));
      pending_reqs.push_back(make_req(4'd5, 48'h123, pool_mac(2), 1));
      pending_reqs.push_back(make_req(4'd5, mlbf_pkg::BROADCAST_MAC, pool_mac(3), 1));
      pending_reqs.push_back(make_req(4'd2, pool_mac(2), pool_mac(1), 1));
      pending_reqs.push_back(make_req(4'd2, pool_mac(1), pool_mac(1), 1));
      pending_reqs.push_back(make_req(4'd2, 48'h5, pool_mac(1), 1));
      pending_reqs.push_back(make_req(4'd2, mlbf_pkg::BROADCAST_MAC, pool_mac(1), 1));
      pending_reqs.push_back(make_req(4'd2, 48'h0, pool_mac(2), 1));
      pending_reqs.push_back(make_req(4'd5, 48'h0, pool_mac(1), 1));
      pending_reqs.push_back(make_req(4'd5, 48'h0, pool_mac(2), 1));
      pending_reqs.push_back(make_req(4'd9, 48'h0, pool_mac(2), 1));
      pending_reqs.push_back(make_req(4'd15, mlbf_pkg::BROADCAST_MAC, 48'hFFFF_FFFF_FFFF, 1));
      pending_reqs.push_back(make_req(4'd0, 48'hAAAA_AAAA_AAAA, 48'h0, 1));
      pending_reqs.push_back(make_req(4'd0, 48'h5555_5555_5555, 48'h0, 1));
      wait_drained();
      write_csr(mlbf_pkg::CSR_UPLINK_PORT, 5'd0);
      write_csr(mlbf_pkg::CSR_PORT_COUNT, 5'd5);
      pending_reqs.push_back(make_req(4'd0, mlbf_pkg::BROADCAST_MAC, pool_mac(40), 1));
      wait_drained();

      // Random phases over several register settings; the pool outgrows the
      // table so the full case shows up late in the run.
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(mlbf_pkg::CSR_UPLINK_PORT,
                   (ph == 5) ? 5'd15 : 5'($urandom_range(0, 15)));
         write_csr(mlbf_pkg::CSR_PORT_COUNT, (ph == 2) ? 5'd0 : (ph == 4) ? 5'd16 :
                   5'($urandom_range(0, 31)));
         allow_gaps = (ph < 5);
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            ing = ($urandom_range(0, 2) == 0) ? sh_uplink : 4'($urandom_range(0, 15));
            pending_reqs.push_back(make_req(ing, rand_mac(), rand_mac(),
                                            $urandom_range(0, 9) != 0));
         end
         if (ph == 1) begin
            // pause until everything is out, then resume
            while (pending_reqs.size() > 30) @(posedge clock);
            hold_driver = 1;
            while (start || busy || expected_rsps.size() > 0) @(posedge clock);
            hold_driver = 0;
         end
         wait_drained();
      end

      $display("covered %0d requests, %0d results, %0d table entries in use",
               accepted, results_seen, tbl_used);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  expected_rsps.size());
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/mlbf_pkg.sv
hw/rtl/mlbf_ram.sv
hw/rtl/mlbf_front.sv
hw/rtl/mlbf_back.sv
hw/rtl/mac_learning_bridge_forwarder_unit.sv
test/tb.sv
